/* sv/assert_macros.svh */
// Assertion macros shared by the sample decompressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define CHK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Whenever the first condition holds, the second must hold in the same cycle.
`define CHK_IMPLY(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

`endif

/* sv/it214_pkg.sv */
// Types and constants of the IT214 sample decompressor.
package it214_pkg;

  localparam logic [15:0] MAX_BLOCK_SAMPLES = 16'd32768;
  localparam logic [4:0] WIDE_8 = 5'd9;
  localparam logic [4:0] WIDE_16 = 5'd17;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic block_start;
    logic [15:0] block_samples;
  } item_t;

  typedef struct packed {
    logic [15:0] sample_value;
    logic last_in_run;
    logic block_done;
  } result_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic block_start;
    logic [15:0] samples;
  } cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

/* sv/it214_front.sv */
// Input stage: accepts items, saturates the block count and queues commands.
module it214_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  it214_pkg::item_t item,
  output logic cmd_valid,
  output it214_pkg::cmd_t cmd,
  input  logic cmd_pop
);

  it214_pkg::cmd_t slots [2];
  logic wptr;
  logic rptr;
  logic [1:0] cnt;
  logic do_push;
  logic do_pop;
  it214_pkg::cmd_t cmd_in;

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = slots[rptr];
  assign do_push = push && !full;
  assign do_pop = cmd_pop && cmd_valid;

  always_comb begin
    cmd_in.packed_byte = item.packed_byte;
    cmd_in.block_start = item.block_start;
    cmd_in.samples = (item.block_samples > it214_pkg::MAX_BLOCK_SAMPLES) ?
                     it214_pkg::MAX_BLOCK_SAMPLES : item.block_samples;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* sv/it214_res_fifo.sv */
// Result queue between the decoder and the result port.
module it214_res_fifo (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  it214_pkg::result_t wr_data,
  output logic res_full,
  input  logic pop,
  output logic empty,
  output it214_pkg::result_t result
);

  it214_pkg::result_t slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] cnt;
  logic do_wr;
  logic do_rd;

  assign res_full = (cnt == 3'd4);
  assign empty = (cnt == 3'd0);
  assign result = slots[rptr];
  assign do_wr = wr_en && !res_full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 2'd0;
      rptr <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 2'd1;
      end
      if (do_rd) begin
        rptr <= rptr + 2'd1;
      end
      case ({do_wr, do_rd})
        2'b10: cnt <= cnt + 3'd1;
        2'b01: cnt <= cnt - 3'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* sv/it214_engine.sv */
// Decoder core: merges bytes into the bit buffer and decodes one field per cycle unless stalled.
module it214_engine (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_bit,
  input  logic cmd_valid,
  input  it214_pkg::cmd_t cmd,
  output logic cmd_pop,
  output logic res_push,
  output it214_pkg::result_t res_data,
  input  logic res_full
);

  it214_pkg::state_t state;
  it214_pkg::state_t state_next;
  logic mode;
  logic [31:0] bit_buffer;
  logic [5:0] bits_held;
  logic [4:0] field_width;
  logic [15:0] running_value;
  logic [15:0] samples_left;
  logic [3:0] n;
  logic pend_valid;
  it214_pkg::result_t pend;

  logic [31:0] bit_buffer_next;
  logic [5:0] bits_held_next;
  logic [4:0] field_width_next;
  logic [15:0] running_value_next;
  logic [15:0] samples_left_next;
  logic [3:0] n_next;
  logic pend_valid_next;
  it214_pkg::result_t pend_next;

  logic [4:0] w;
  logic [4:0] wide;
  logic [4:0] esc_w;
  logic [31:0] fmask;
  logic [16:0] v;
  logic [16:0] vmask17;
  logic [16:0] border;
  logic [17:0] band_top;
  logic is_low;
  logic is_top;
  logic low_esc;
  logic mid_esc;
  logic top_esc;
  logic escape;
  logic [4:0] nw_low_raw;
  logic [4:0] nw_mid_raw;
  logic [4:0] nw_raw;
  logic [4:0] nw;
  logic [7:0] nw_top;
  logic [5:0] used;
  logic [31:0] delta32;
  logic [15:0] delta16;
  logic [15:0] run_sum;
  logic stop_pre;
  logic low_wait;
  logic [31:0] base_buffer;
  logic [5:0] base_held;
  logic [15:0] base_left;

  assign w = field_width;
  assign wide = mode ? it214_pkg::WIDE_16 : it214_pkg::WIDE_8;
  assign esc_w = mode ? 5'd4 : 5'd3;
  assign fmask = (32'd1 << w) - 32'd1;
  assign v = 17'(bit_buffer & fmask);
  assign vmask17 = mode ? 17'h0FFFF : 17'h000FF;
  assign border = (vmask17 >> (wide - w)) - (mode ? 17'd8 : 17'd4);
  assign band_top = {1'b0, border} + (mode ? 18'd16 : 18'd8);
  assign is_low = (w < 5'd7);
  assign is_top = (w == wide);

  always_comb begin
    low_esc = is_low && (v == (17'd1 << (w - 5'd1)));
    mid_esc = !is_low && !is_top && (v > border) && ({1'b0, v} <= band_top);
    top_esc = is_top && ((v & (17'd1 << (wide - 5'd1))) != 17'd0);
    escape = low_esc || mid_esc || top_esc;
    nw_low_raw = 5'(((bit_buffer >> w) & (mode ? 32'hF : 32'h7)) + 32'd1);
    nw_mid_raw = 5'(v - border);
    nw_raw = low_esc ? nw_low_raw : nw_mid_raw;
    nw_top = 8'(v + 17'd1);
    if (top_esc) begin
      if (nw_top == 8'd0 || nw_top > {3'b000, wide}) begin
        nw = w;
      end else begin
        nw = nw_top[4:0];
      end
    end else begin
      nw = (nw_raw < w) ? nw_raw : nw_raw + 5'd1;
    end
    used = low_esc ? {1'b0, w} + {1'b0, esc_w} : {1'b0, w};
    if (is_top) begin
      delta32 = {15'd0, v};
    end else if ((v & (17'd1 << (w - 5'd1))) != 17'd0) begin
      delta32 = {15'd0, v} | ~fmask;
    end else begin
      delta32 = {15'd0, v};
    end
    delta16 = delta32[15:0];
    run_sum = (running_value + delta16) & vmask17[15:0];
    stop_pre = (samples_left == 16'd0) || (n == 4'd8) || (w == 5'd0) || (w > wide) ||
               (bits_held < {1'b0, w});
    low_wait = low_esc && (bits_held < ({1'b0, w} + {1'b0, esc_w}));
  end

  always_comb begin
    state_next = state;
    bit_buffer_next = bit_buffer;
    bits_held_next = bits_held;
    field_width_next = field_width;
    running_value_next = running_value;
    samples_left_next = samples_left;
    n_next = n;
    pend_valid_next = pend_valid;
    pend_next = pend;
    cmd_pop = 1'b0;
    res_push = 1'b0;
    res_data = pend;
    base_buffer = bit_buffer;
    base_held = bits_held;
    base_left = samples_left;
    unique case (state)
      it214_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.block_start) begin
            base_buffer = 32'd0;
            base_held = 6'd0;
            base_left = cmd.samples;
            field_width_next = wide;
            running_value_next = 16'd0;
          end
          bit_buffer_next = base_buffer;
          bits_held_next = base_held;
          samples_left_next = base_left;
          if (base_left != 16'd0) begin
            if (base_held <= 6'd24) begin
              bit_buffer_next = base_buffer | ({24'd0, cmd.packed_byte} << base_held);
              bits_held_next = base_held + 6'd8;
            end
            n_next = 4'd0;
            state_next = it214_pkg::ST_RUN;
          end
        end
      end
      it214_pkg::ST_RUN: begin
        if (stop_pre || low_wait) begin
          res_data.last_in_run = 1'b1;
          if (!(pend_valid && res_full)) begin
            res_push = pend_valid;
            pend_valid_next = 1'b0;
            if (samples_left == 16'd0) begin
              bit_buffer_next = 32'd0;
              bits_held_next = 6'd0;
            end
            state_next = it214_pkg::ST_IDLE;
          end
        end else if (escape) begin
          bit_buffer_next = bit_buffer >> used;
          bits_held_next = bits_held - used;
          field_width_next = nw;
        end else if (!(pend_valid && res_full)) begin
          res_data.last_in_run = 1'b0;
          res_push = pend_valid;
          bit_buffer_next = bit_buffer >> used;
          bits_held_next = bits_held - used;
          running_value_next = run_sum;
          samples_left_next = samples_left - 16'd1;
          n_next = n + 4'd1;
          pend_valid_next = 1'b1;
          pend_next.sample_value = run_sum;
          pend_next.last_in_run = 1'b0;
          pend_next.block_done = (samples_left == 16'd1);
        end
      end
      default: begin
        state_next = it214_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    n <= n_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= it214_pkg::ST_IDLE;
      mode <= 1'b0;
      bit_buffer <= 32'd0;
      bits_held <= 6'd0;
      field_width <= it214_pkg::WIDE_8;
      running_value <= 16'd0;
      samples_left <= 16'd0;
      pend_valid <= 1'b0;
    end else if (cfg_we) begin
      state <= it214_pkg::ST_IDLE;
      mode <= cfg_bit;
      bit_buffer <= 32'd0;
      bits_held <= 6'd0;
      field_width <= cfg_bit ? it214_pkg::WIDE_16 : it214_pkg::WIDE_8;
      running_value <= 16'd0;
      samples_left <= 16'd0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      bit_buffer <= bit_buffer_next;
      bits_held <= bits_held_next;
      field_width <= field_width_next;
      running_value <= running_value_next;
      samples_left <= samples_left_next;
      pend_valid <= pend_valid_next;
    end
  end

endmodule

/* sv/it214_sample_decompressor.sv */
// Top level of the IT214 compressed sample block decoder.
// Items enter on a queue-style port: an item transaction happens when push
// is high and full is low. Each item carries one packed byte, a block start
// flag and the block's sample count. Results leave on a queue-style port: the
// oldest result sits on result while empty is low, and pop takes it.
// The single mode register is written through cfg_valid/cfg_ready/cfg_data;
// ready is always high, and a write also closes any open block.
// An item that finds no open block is taken without decoding. Any other
// item loads its byte, then decodes fields, escapes and samples, and then
// closes the run; a run holds up to 8 samples and the escapes that fit in
// the 32-bit buffer. A decoded sample waits in the decoder's pending
// register and is written to the result queue only once the next sample
// or the end of the run tells whether it ends the run.
// A two-entry command queue in front of the decoder lets new items be taken
// while the decoder works. When the receiver stops popping, the four-entry
// result queue fills, the decoder waits, and then full rises.
// Reset selects 8-bit mode, empties both queues and clears the decoder state.
module it214_sample_decompressor (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  it214_pkg::item_t item,
  output logic empty,
  input  logic pop,
  output it214_pkg::result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  `include "assert_macros.svh"

  logic cmd_valid;
  it214_pkg::cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  it214_pkg::result_t res_data;
  logic res_full;

  assign cfg_ready = 1'b1;

  it214_front u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop)
  );

  it214_engine u_engine (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_valid),
    .cfg_bit(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop),
    .res_push(res_push),
    .res_data(res_data),
    .res_full(res_full)
  );

  it214_res_fifo u_res_fifo (
    .clk(clk),
    .rst(rst),
    .wr_en(res_push),
    .wr_data(res_data),
    .res_full(res_full),
    .pop(pop),
    .empty(empty),
    .result(result)
  );

  `CHK_NEVER(a_res_no_overflow, res_push && res_full, "Result written into a full queue.")
  `CHK_NEVER(a_cmd_pop_valid, cmd_pop && !cmd_valid, "Command taken from an empty queue.")
  `CHK_IMPLY(a_done_is_last, res_push && res_data.block_done, res_data.last_in_run, "Block end not last.")

endmodule
